[design/ifd_pkg.sv]
// Package for the IQ frame deframer: result item type, kind codes,
// register map and default sizes. No dependencies.
package ifd_pkg;

  // Default sizes
  localparam int FRAME_BYTES_DEF = 512;
  localparam int MAX_RX_DEF      = 8;

  // Frame layout
  localparam logic [7:0] SYNC_BYTE    = 8'h7F;
  localparam int         SYNC_BYTES   = 3;
  localparam int         HEADER_BYTES = 8;

  // Configuration port
  localparam int          CFG_ADDR_W   = 3;
  localparam int          CFG_DATA_W   = 32;
  localparam int          RX_CNT_W     = 4;
  localparam logic        REG_RX_COUNT = 1'b0;  // word select, paddr[2]

  // Result kinds
  localparam logic [1:0] KIND_IQ   = 2'd0;
  localparam logic [1:0] KIND_MIC  = 2'd1;
  localparam logic [1:0] KIND_CTRL = 2'd2;
  localparam logic [1:0] KIND_SYNC = 2'd3;

  // Byte index within a group where an iq pair and a mic sample finish
  localparam logic [2:0] GB_IQ_LAST  = 3'd5;
  localparam logic [2:0] GB_MIC_LAST = 3'd7;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         receiver;
    logic signed [23:0] i_sample;
    logic signed [23:0] q_sample;
    logic signed [15:0] voice_sample;
    logic               ptt;
    logic               dash;
    logic               dot;
    logic               adc_overflow;
    logic [2:0]         user_inputs;
    logic [4:0]         telemetry_address;
    logic [31:0]        telemetry_data;
  } out_item_t;

endpackage

[design/ifd_in_if.sv]
// Byte input channel of the IQ frame deframer: valid/ready and one frame byte.
// No dependencies.
interface ifd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;

  modport source (output valid, output frame_byte, input ready);
  modport sink   (input valid, input frame_byte, output ready);
endinterface

[design/ifd_out_if.sv]
// Result channel of the IQ frame deframer: valid/ready and one result item.
// Depends on ifd_pkg for the item type.
interface ifd_out_if;
  logic              valid;
  logic              ready;
  ifd_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[design/iq_frame_deframer_unit.sv]
// Top level of the IQ frame deframer: frame tracking, decode and result register.
// Depends on ifd_pkg, ifd_in_if and ifd_out_if.
//
// Channel     | Direction | Handshake          | Payload
// in_stream   | in        | valid/ready        | frame_byte[7:0]
// out_stream  | out       | valid/ready        | out_item_t (kind, samples, control)
// cfg (APB)   | in        | psel/penable/pready| receiver_count at byte address 0
//
// One byte is taken per cycle unless stalled, decoded in the cycle it is taken
// and its result, if any, lands in the result register at the same edge.
// A byte is accepted while the result register is empty or being drained.
// Reset (rst_n low, synchronous) returns to the first sync byte of a frame
// with receiver_count = 1.
// The receiver count is latched at the first byte of every frame.
module iq_frame_deframer_unit #(
  parameter int FRAME_BYTES = ifd_pkg::FRAME_BYTES_DEF,
  parameter int MAX_RX      = ifd_pkg::MAX_RX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ifd_in_if.sink                         in_stream,
  ifd_out_if.source                      out_stream,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ifd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ifd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ifd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ifd_pkg::*;

  localparam int PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0]   PosLast  = PosW'(FRAME_BYTES - 1);
  localparam logic [PosW:0]     FrameLen = (PosW + 1)'(FRAME_BYTES);
  localparam logic [PosW-1:0]   PosSyncE = PosW'(SYNC_BYTES);
  localparam logic [PosW-1:0]   PosHdrE  = PosW'(HEADER_BYTES);
  localparam logic [PosW-1:0]   PosHdrL  = PosW'(HEADER_BYTES - 1);
  localparam logic [RX_CNT_W-1:0] MaxRx  = RX_CNT_W'(MAX_RX);

  // Registers
  logic [RX_CNT_W-1:0] rx_count_r;
  logic [RX_CNT_W-1:0] frame_rx_r, frame_rx_nxt;
  logic [PosW-1:0]     pos_r, pos_nxt;
  logic [39:0]         ctrl_hold_r, ctrl_hold_nxt;
  logic [2:0]          rx_idx_r, rx_idx_nxt;
  logic [2:0]          group_byte_r, group_byte_nxt;
  logic [47:0]         sample_r, sample_nxt;
  logic                frame_bad_r, frame_bad_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  // Per-byte working values
  logic                in_fire;
  logic                cfg_wr;
  logic                frame_start;
  logic [RX_CNT_W-1:0] rx_clamped;
  logic [RX_CNT_W-1:0] frx_eff;
  logic [2:0]          ridx_eff;
  logic [2:0]          gb_eff;
  logic                bad_eff;
  logic [5:0]          group_len;
  logic                padding;
  logic [39:0]         ctrl_shift;
  logic [47:0]         sample_shift;
  logic [7:0]          c0;
  logic [7:0]          c1;
  logic                res_valid;
  out_item_t           res;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RX_COUNT);
  assign prdata = (paddr[2] == REG_RX_COUNT) ?
                  CFG_DATA_W'(rx_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= RX_CNT_W'(1);
    end else if (cfg_wr) begin
      rx_count_r <= pwdata[RX_CNT_W-1:0];
    end
  end

  // Handshake: take a byte while the result register is free or draining
  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign in_fire         = in_stream.valid && in_stream.ready;

  // Clamp the receiver count into 1..MAX_RX
  always_comb begin
    if (rx_count_r == '0) begin
      rx_clamped = RX_CNT_W'(1);
    end else if (rx_count_r > MaxRx) begin
      rx_clamped = MaxRx;
    end else begin
      rx_clamped = rx_count_r;
    end
  end

  // Frame start resets the per-frame state before the byte is decoded
  assign frame_start = (pos_r == '0);
  assign frx_eff     = frame_start ? rx_clamped : frame_rx_r;
  assign ridx_eff    = frame_start ? 3'd0 : rx_idx_r;
  assign gb_eff      = frame_start ? 3'd0 : group_byte_r;
  assign bad_eff     = frame_start ? 1'b0 : frame_bad_r;

  // Group length 6*rx + 2 and the padding test at a group boundary
  assign group_len = {frx_eff, 2'b00} + {1'b0, frx_eff, 1'b0} + 6'd2;
  assign padding   = (gb_eff == 3'd0) && (ridx_eff == 3'd0) &&
                     (({1'b0, pos_r} + (PosW + 1)'(group_len)) > FrameLen);

  assign ctrl_shift   = {ctrl_hold_r[31:0], in_stream.frame_byte};
  assign sample_shift = {sample_r[39:0], in_stream.frame_byte};
  assign c0           = ctrl_shift[39:32];
  assign c1           = ctrl_shift[31:24];

  // Decode one byte
  always_comb begin
    frame_bad_nxt  = bad_eff;
    rx_idx_nxt     = ridx_eff;
    group_byte_nxt = gb_eff;
    ctrl_hold_nxt  = ctrl_hold_r;
    sample_nxt     = sample_r;
    res_valid      = 1'b0;
    res            = '0;
    if (bad_eff) begin
      // drop the rest of a bad frame
    end else if (pos_r < PosSyncE) begin
      if (in_stream.frame_byte != SYNC_BYTE) begin
        frame_bad_nxt = 1'b1;
        res.kind      = KIND_SYNC;
        res_valid     = 1'b1;
      end
    end else if (pos_r < PosHdrE) begin
      ctrl_hold_nxt = ctrl_shift;
      if (pos_r == PosHdrL) begin
        res.kind              = KIND_CTRL;
        res.ptt               = c0[0];
        res.dash              = c0[1];
        res.dot               = c0[2];
        res.telemetry_address = c0[7:3];
        res.telemetry_data    = ctrl_shift[31:0];
        if (c0[7:3] == 5'd0) begin
          res.adc_overflow = c1[0];
          res.user_inputs  = ~c1[3:1];
        end
        res_valid = 1'b1;
      end
    end else if (!padding) begin
      sample_nxt     = sample_shift;
      group_byte_nxt = gb_eff + 3'd1;
      if (gb_eff == GB_IQ_LAST) begin
        res.kind     = KIND_IQ;
        res.receiver = ridx_eff;
        res.i_sample = sample_shift[47:24];
        res.q_sample = sample_shift[23:0];
        res_valid    = 1'b1;
        if ((RX_CNT_W'(ridx_eff) + RX_CNT_W'(1)) < frx_eff) begin
          rx_idx_nxt     = ridx_eff + 3'd1;
          group_byte_nxt = 3'd0;
        end
      end else if (gb_eff == GB_MIC_LAST) begin
        res.kind         = KIND_MIC;
        res.voice_sample = sample_shift[15:0];
        res_valid        = 1'b1;
        rx_idx_nxt       = 3'd0;
        group_byte_nxt   = 3'd0;
      end
    end
  end

  assign frame_rx_nxt = frx_eff;
  assign pos_nxt      = (pos_r == PosLast) ? '0 : pos_r + PosW'(1);

  // Result register: load on a byte with a result, clear when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_stream.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire && res_valid) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end
  end

  // Frame state: advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      frame_rx_r   <= RX_CNT_W'(1);
      rx_idx_r     <= '0;
      group_byte_r <= '0;
      frame_bad_r  <= 1'b0;
      ctrl_hold_r  <= '0;
      sample_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        pos_r        <= pos_nxt;
        frame_rx_r   <= frame_rx_nxt;
        rx_idx_r     <= rx_idx_nxt;
        group_byte_r <= group_byte_nxt;
        frame_bad_r  <= frame_bad_nxt;
        ctrl_hold_r  <= ctrl_hold_nxt;
        sample_r     <= sample_nxt;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_stream.valid = out_valid_r;
  assign out_stream.item  = out_item_r;

`ifndef SYNTH
  // A stalled input means a result is pending
  a_ready_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stream.ready |-> out_valid_r)
    else $error("input stalled with empty result register");

  // Receiver index stays below the latched frame count
  a_rx_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (RX_CNT_W'(rx_idx_r) < frame_rx_r))
    else $error("receiver index beyond frame receiver count");

  // Last byte of a frame wraps the position to the frame start
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pos_r == PosLast) |=> (pos_r == '0))
    else $error("frame position did not wrap");

  // A good header always ends in a control record
  a_ctrl_record: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pos_r == PosHdrL && !frame_bad_r) |=>
    (out_valid_r && out_item_r.kind == KIND_CTRL))
    else $error("missing control record at end of header");
`endif

endmodule
